@@ design/pcdq_pkg.sv @@
// Shared constants, register codes and types of the point cloud decimate and quantize block.
package pcdq_pkg;

    localparam int DIM_BITS     = 12;
    localparam int FACTOR_BITS  = 6;
    localparam int COORD_BITS   = 32;
    localparam int COLOR_BITS   = 8;
    localparam int CM_BITS      = 16;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(7);
    localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = DIM_BITS'(480);

    // Scale from meters to centimeters.
    localparam logic [6:0] SCALE_CM = 7'd100;

    // Register word indexes on the configuration port.
    localparam logic [1:0] REG_FACTOR = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef logic [DIM_BITS-1:0]    dim_t;
    typedef logic [DIM_BITS:0]      dim_ext_t;
    typedef logic [FACTOR_BITS-1:0] factor_t;

    // One converted coordinate and its clip flag.
    typedef struct packed {
        logic signed [CM_BITS-1:0] value;
        logic                      clip;
    } cm_t;

endpackage

@@ design/pcdq_if.sv @@
// Stream interfaces carrying input points and output results.
interface pcdq_point_if;
    logic                                valid;
    logic                                ready;
    logic [pcdq_pkg::COORD_BITS-1:0]     x_bits;
    logic [pcdq_pkg::COORD_BITS-1:0]     y_bits;
    logic [pcdq_pkg::COORD_BITS-1:0]     z_bits;
    logic [pcdq_pkg::COLOR_BITS-1:0]     red_in;
    logic [pcdq_pkg::COLOR_BITS-1:0]     green_in;
    logic [pcdq_pkg::COLOR_BITS-1:0]     blue_in;

    modport source (
        output valid, x_bits, y_bits, z_bits, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, x_bits, y_bits, z_bits, red_in, green_in, blue_in,
        output ready
    );
endinterface

interface pcdq_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcdq_pkg::CM_BITS-1:0] x_cm;
    logic signed [pcdq_pkg::CM_BITS-1:0] y_cm;
    logic signed [pcdq_pkg::CM_BITS-1:0] z_cm;
    logic [pcdq_pkg::COLOR_BITS-1:0]     red_out;
    logic [pcdq_pkg::COLOR_BITS-1:0]     green_out;
    logic [pcdq_pkg::COLOR_BITS-1:0]     blue_out;
    logic                                clipped;
    logic                                frame_last;

    modport source (
        output valid, x_cm, y_cm, z_cm, red_out, green_out, blue_out, clipped, frame_last,
        input  ready
    );
    modport sink (
        input  valid, x_cm, y_cm, z_cm, red_out, green_out, blue_out, clipped, frame_last,
        output ready
    );
endinterface

@@ design/pcdq_to_cm.sv @@
// Converts one binary32 coordinate in meters to saturated signed 16-bit centimeters.
module pcdq_to_cm (
    input  logic [pcdq_pkg::COORD_BITS-1:0] bits,
    output pcdq_pkg::cm_t                   cm
);

    logic        sign;
    logic [7:0]  ef;
    logic [22:0] frac;
    logic [30:0] prod;
    logic        hi;
    logic [24:0] q_trunc;
    logic        round_bit;
    logic        sticky;
    logic [24:0] q;
    logic signed [9:0] k;
    logic signed [9:0] neg_k;
    logic [4:0]  shamt;
    logic [24:0] mag;
    logic        big;
    logic        is_nan;

    // The significand times 100 fits in 31 bits; it is rounded back to 24 significant bits
    // as a binary32 multiply would, then shifted down to the integer part.
    assign sign = bits[31];
    assign ef   = bits[30:23];
    assign frac = bits[22:0];
    assign prod = 31'({1'b1, frac}) * 31'(pcdq_pkg::SCALE_CM);
    assign hi   = prod[30];

    always_comb
    begin
        if (hi)
        begin
            q_trunc   = 25'(prod[30:7]);
            round_bit = prod[6];
            sticky    = |prod[5:0];
            k         = $signed({2'b00, ef}) - 10'sd143;
        end
        else
        begin
            q_trunc   = 25'(prod[29:6]);
            round_bit = prod[5];
            sticky    = |prod[4:0];
            k         = $signed({2'b00, ef}) - 10'sd144;
        end
        q     = q_trunc + 25'(round_bit && (sticky || q_trunc[0]));
        neg_k = -k;
        shamt = neg_k[4:0];

        is_nan = 1'b0;
        big    = 1'b0;
        mag    = '0;
        if (ef == 8'hFF)
        begin
            is_nan = (frac != '0);
            big    = (frac == '0);
        end
        else if (ef != 8'h00)
        begin
            if (k >= 10'sd0)
            begin
                big = 1'b1;
            end
            else if (k > -10'sd32)
            begin
                mag = q >> shamt;
            end
        end

        if (is_nan)
        begin
            cm.value = '0;
            cm.clip  = 1'b1;
        end
        else if (!sign)
        begin
            if (big || mag > 25'd32767)
            begin
                cm.value = 16'sh7FFF;
                cm.clip  = 1'b1;
            end
            else
            begin
                cm.value = $signed(mag[15:0]);
                cm.clip  = 1'b0;
            end
        end
        else
        begin
            if (big || mag > 25'd32768)
            begin
                cm.value = 16'sh8000;
                cm.clip  = 1'b1;
            end
            else
            begin
                cm.value = $signed(16'(16'd0 - mag[15:0]));
                cm.clip  = 1'b0;
            end
        end
    end

endmodule

@@ design/point_cloud_decimate_quantize.sv @@
// Top level of the point cloud decimate and quantize block.
//
// Points of an organized depth-camera cloud arrive in raster order, one per transfer on the
// points channel, and the block accepts one point every clock cycle as long as the results
// channel keeps up. A point is kept when both its column and its row equal N-1 modulo N
// (N is the decimation factor, zero acting as one) and it lies inside the configured frame.
// Each coordinate of a kept point is scaled by 100 with binary32 rounding and truncated
// toward zero to signed 16-bit centimeters; out-of-range values saturate and NaN gives zero,
// both raising clipped. Color passes through and frame_last marks the last kept point of a
// frame. The decimation decision and position counters work at the
// point transfer and fill the input stage register, the float conversion sits between that
// register and the result register. Dropped points produce no result and no bubble. The
// output register lets a new point enter while a finished result waits to be taken.
// Registers (APB, byte addresses): 0x0 decimation_factor, 0x4 frame_width,
// 0x8 frame_height. Write them only while the block is idle; position counters are not
// cleared by a write.
module point_cloud_decimate_quantize (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcdq_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [pcdq_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [pcdq_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    pcdq_point_if.sink                          points,
    pcdq_result_if.source                       results
);

    // Configuration registers.
    pcdq_pkg::factor_t factor_reg;
    pcdq_pkg::dim_t    width_reg;
    pcdq_pkg::dim_t    height_reg;

    // Raster position and phase counters.
    pcdq_pkg::dim_t    col_idx_reg, col_idx_next;
    pcdq_pkg::dim_t    row_idx_reg, row_idx_next;
    pcdq_pkg::factor_t col_phase_reg, col_phase_next;
    pcdq_pkg::factor_t row_phase_reg, row_phase_next;

    // Input stage: holds a kept point waiting for conversion.
    logic                                s1_valid_reg;
    logic [pcdq_pkg::COORD_BITS-1:0]     s1_x_reg, s1_y_reg, s1_z_reg;
    logic [pcdq_pkg::COLOR_BITS-1:0]     s1_red_reg, s1_green_reg, s1_blue_reg;
    logic                                s1_last_reg;

    // Result register.
    logic                                out_valid_reg;
    logic signed [pcdq_pkg::CM_BITS-1:0] x_cm_reg, y_cm_reg, z_cm_reg;
    logic [pcdq_pkg::COLOR_BITS-1:0]     red_reg, green_reg, blue_reg;
    logic                                clipped_reg;
    logic                                last_reg;

    pcdq_pkg::factor_t n;
    pcdq_pkg::factor_t nm1;
    logic              keep;
    logic              frame_end;
    logic              in_xfer;
    logic              out_free;
    logic              s1_move;
    logic              cfg_write;
    pcdq_pkg::cm_t     x_conv, y_conv, z_conv;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; no wait states.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= pcdq_pkg::FACTOR_RESET;
            width_reg  <= pcdq_pkg::WIDTH_RESET;
            height_reg <= pcdq_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                pcdq_pkg::REG_FACTOR: factor_reg <= pwdata[pcdq_pkg::FACTOR_BITS-1:0];
                pcdq_pkg::REG_WIDTH:  width_reg  <= pwdata[pcdq_pkg::DIM_BITS-1:0];
                pcdq_pkg::REG_HEIGHT: height_reg <= pwdata[pcdq_pkg::DIM_BITS-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pcdq_pkg::REG_FACTOR: prdata = pcdq_pkg::APB_DATA_BITS'(factor_reg);
            pcdq_pkg::REG_WIDTH:  prdata = pcdq_pkg::APB_DATA_BITS'(width_reg);
            pcdq_pkg::REG_HEIGHT: prdata = pcdq_pkg::APB_DATA_BITS'(height_reg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. Only kept points occupy the input stage, so the points channel
    // stalls only when a kept point is parked there and the result register is full.
    // ------------------------------------------------------------------
    assign out_free     = !out_valid_reg || results.ready;
    assign s1_move      = s1_valid_reg && out_free;
    assign points.ready = !s1_valid_reg || out_free;
    assign in_xfer      = points.valid && points.ready;

    // ------------------------------------------------------------------
    // Decimation decision and raster counters.
    // ------------------------------------------------------------------
    always_comb
    begin
        n   = (factor_reg == '0) ? pcdq_pkg::factor_t'(1) : factor_reg;
        nm1 = n - pcdq_pkg::factor_t'(1);

        keep = (col_phase_reg == nm1) && (row_phase_reg == nm1) &&
               (col_idx_reg < width_reg) && (row_idx_reg < height_reg);

        // The last kept point of a frame has no further kept column or row after it.
        frame_end = ((pcdq_pkg::dim_ext_t'(row_idx_reg) + pcdq_pkg::dim_ext_t'(n)) >=
                     pcdq_pkg::dim_ext_t'(height_reg)) &&
                    ((pcdq_pkg::dim_ext_t'(col_idx_reg) + pcdq_pkg::dim_ext_t'(n)) >=
                     pcdq_pkg::dim_ext_t'(width_reg));

        col_idx_next   = col_idx_reg;
        row_idx_next   = row_idx_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        if ((pcdq_pkg::dim_ext_t'(col_idx_reg) + pcdq_pkg::dim_ext_t'(1)) >=
            pcdq_pkg::dim_ext_t'(width_reg))
        begin
            col_idx_next   = '0;
            col_phase_next = '0;
            if ((pcdq_pkg::dim_ext_t'(row_idx_reg) + pcdq_pkg::dim_ext_t'(1)) >=
                pcdq_pkg::dim_ext_t'(height_reg))
            begin
                row_idx_next   = '0;
                row_phase_next = '0;
            end
            else
            begin
                row_idx_next   = row_idx_reg + pcdq_pkg::dim_t'(1);
                row_phase_next = (row_phase_reg >= nm1) ? '0 :
                                 row_phase_reg + pcdq_pkg::factor_t'(1);
            end
        end
        else
        begin
            col_idx_next   = col_idx_reg + pcdq_pkg::dim_t'(1);
            col_phase_next = (col_phase_reg >= nm1) ? '0 :
                             col_phase_reg + pcdq_pkg::factor_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_idx_reg   <= '0;
            row_idx_reg   <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
        end
        else if (in_xfer)
        begin
            col_idx_reg   <= col_idx_next;
            row_idx_reg   <= row_idx_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
        end
    end

    // ------------------------------------------------------------------
    // Input stage register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= keep;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && keep)
        begin
            s1_x_reg     <= points.x_bits;
            s1_y_reg     <= points.y_bits;
            s1_z_reg     <= points.z_bits;
            s1_red_reg   <= points.red_in;
            s1_green_reg <= points.green_in;
            s1_blue_reg  <= points.blue_in;
            s1_last_reg  <= frame_end;
        end
    end

    // ------------------------------------------------------------------
    // Float to centimeter conversion, one unit per coordinate.
    // ------------------------------------------------------------------
    pcdq_to_cm u_conv_x (.bits(s1_x_reg), .cm(x_conv));
    pcdq_to_cm u_conv_y (.bits(s1_y_reg), .cm(y_conv));
    pcdq_to_cm u_conv_z (.bits(s1_z_reg), .cm(z_conv));

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            x_cm_reg    <= x_conv.value;
            y_cm_reg    <= y_conv.value;
            z_cm_reg    <= z_conv.value;
            clipped_reg <= x_conv.clip || y_conv.clip || z_conv.clip;
            red_reg     <= s1_red_reg;
            green_reg   <= s1_green_reg;
            blue_reg    <= s1_blue_reg;
            last_reg    <= s1_last_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.x_cm       = x_cm_reg;
    assign results.y_cm       = y_cm_reg;
    assign results.z_cm       = z_cm_reg;
    assign results.red_out    = red_reg;
    assign results.green_out  = green_reg;
    assign results.blue_out   = blue_reg;
    assign results.clipped    = clipped_reg;
    assign results.frame_last = last_reg;

`ifndef SYNTHESIS
    // A parked kept point with a full, stalled result register must hold off new points.
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !results.ready) |-> !points.ready)
        else $error("point accepted while the input stage could not drain");

    // A new result only appears when a kept point was waiting in the input stage.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(s1_valid_reg))
        else $error("result appeared without a kept point");

    // A kept point moving on always lands in the result register.
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> results.valid)
        else $error("kept point lost between stages");
`endif

endmodule
